// File: hdl/krat_pkg.sv
// ----------------------------------------------------------------------------
// krat_pkg
// Shared constants and helpers for the key repeat accelerating timer.
// ----------------------------------------------------------------------------
package krat_pkg;

	// Field and port widths
	localparam int NOW_BITS      = 64;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int POLICY_BITS   = 2;

	// Parameter defaults
	localparam int TICK_BITS_DEF  = 64;
	localparam int DELAY_BITS_DEF = 16;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_DELAY  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_DELAY = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_STEP   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DELAY    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_UP_DEFAULT   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_UP_POLICY    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_DEFAULT = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_POLICY  = 3'd7;

	// Policy codes; anything else denies
	localparam logic [POLICY_BITS-1:0] POL_DEFAULT = 2'd0;
	localparam logic [POLICY_BITS-1:0] POL_ALLOW   = 2'd1;
	localparam logic [POLICY_BITS-1:0] POL_DENY    = 2'd2;

	typedef logic [POLICY_BITS-1:0] policy_t;

	function automatic logic policy_allows(input policy_t pol, input logic dflt);
		logic allow;
		case (pol)
			POL_DEFAULT: allow = dflt;
			POL_ALLOW:   allow = 1'b1;
			default:     allow = 1'b0;
		endcase
		return allow;
	endfunction

endpackage

// File: hdl/krat_if.sv
// ----------------------------------------------------------------------------
// krat channel interfaces
// Event, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface krat_evt_if import krat_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                key_up;
	logic                key_down;
	logic [NOW_BITS-1:0] now_ticks;

	modport source (output valid, output key_up, output key_down, output now_ticks,
		input ready);
	modport sink (input valid, input key_up, input key_down, input now_ticks,
		output ready);
endinterface

interface krat_res_if;
	logic valid;
	logic ready;
	logic fire;

	modport source (output valid, output fire, input ready);
	modport sink (input valid, input fire, output ready);
endinterface

interface krat_cfg_if import krat_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/key_repeat_accelerating_timer_unit.sv
// ----------------------------------------------------------------------------
// key_repeat_accelerating_timer_unit
// Typematic repeat timer with acceleration for one key.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one key event per request: release flag, press/hold flag and
//   the current tick time. res returns exactly one request per event, with
//   fire set when the event produces an action. cfg writes the eight timing
//   and policy registers by index; it is always ready and should be used only
//   while no event is in flight.
//   Latency: the result for an event is valid in the cycle after the event is
//   accepted. Throughput: one event per cycle while res takes each result; the
//   state update (one tick add, one compare, one saturating subtract and
//   clamp) completes in the accept cycle, so the next event sees it at once.
//   The result register doubles as the only buffer: when res stalls, evt
//   holds ready low until the waiting result is taken.
//   Reset clears all registers and returns the key to idle (next time zero).
// ----------------------------------------------------------------------------
module key_repeat_accelerating_timer_unit import krat_pkg::*; #(
	parameter int TICK_BITS  = TICK_BITS_DEF,
	parameter int DELAY_BITS = DELAY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	krat_evt_if.sink      evt,
	krat_res_if.source    res,
	krat_cfg_if.sink      cfg
);

	localparam int SUM_BITS = (TICK_BITS > DELAY_BITS) ? TICK_BITS : DELAY_BITS;

	// Configuration registers
	logic [DELAY_BITS-1:0] first_delay_q;
	logic [DELAY_BITS-1:0] repeat_delay_q;
	logic [DELAY_BITS-1:0] accel_step_q;
	logic [DELAY_BITS-1:0] min_delay_q;
	logic                  up_default_q;
	policy_t               up_policy_q;
	logic                  down_default_q;
	policy_t               down_policy_q;

	// Repeat state
	logic [TICK_BITS-1:0]  next_time_q;
	logic [DELAY_BITS-1:0] cur_delay_q;

	// Result register
	logic                  res_valid_q;
	logic                  fire_q;

	logic                  evt_take;
	logic [TICK_BITS-1:0]  now;
	logic                  up_fire;
	logic                  press;
	logic [TICK_BITS-1:0]  base_next;
	logic [DELAY_BITS-1:0] base_delay;
	logic [DELAY_BITS-1:0] add_delay;
	logic [SUM_BITS-1:0]   tick_sum;
	logic [DELAY_BITS-1:0] accel_delay;
	logic [DELAY_BITS-1:0] step_delay;
	logic                  fire_d;
	logic [TICK_BITS-1:0]  next_d;
	logic [DELAY_BITS-1:0] delay_d;

	// Accept a new event whenever the result slot is free or being drained
	assign evt.ready = !res_valid_q || res.ready;
	assign evt_take  = evt.valid && evt.ready;
	assign cfg.ready = 1'b1;

	assign res.valid = res_valid_q;
	assign res.fire  = fire_q;

	assign now = evt.now_ticks[TICK_BITS-1:0];

	always_comb begin
		// Release drops the repeat state before the press is looked at
		up_fire    = evt.key_up && policy_allows(up_policy_q, up_default_q);
		base_next  = evt.key_up ? '0 : next_time_q;
		base_delay = evt.key_up ? '0 : cur_delay_q;
		press      = !up_fire && evt.key_down && policy_allows(down_policy_q, down_default_q);

		// Idle start adds start delay or, for an immediate fire, repeat delay
		if (base_next == '0) begin
			add_delay = (first_delay_q == '0) ? repeat_delay_q : first_delay_q;
		end else begin
			add_delay = base_delay;
		end
		tick_sum = SUM_BITS'(now) + SUM_BITS'(add_delay);

		accel_delay = (base_delay >= accel_step_q) ? (base_delay - accel_step_q) : '0;

		fire_d     = up_fire;
		next_d     = base_next;
		delay_d    = base_delay;
		step_delay = base_delay;
		if (press) begin
			if (base_next == '0) begin
				step_delay = repeat_delay_q;
				next_d     = tick_sum[TICK_BITS-1:0];
				fire_d     = (first_delay_q == '0);
			end else if (now >= base_next) begin
				step_delay = accel_delay;
				next_d     = tick_sum[TICK_BITS-1:0];
				fire_d     = 1'b1;
			end
			// Clamp up to the floor after any allowed press
			delay_d = (step_delay < min_delay_q) ? min_delay_q : step_delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_time_q <= '0;
			cur_delay_q <= '0;
			res_valid_q <= 1'b0;
			fire_q      <= 1'b0;
		end else begin
			if (evt_take) begin
				next_time_q <= next_d;
				cur_delay_q <= delay_d;
				fire_q      <= fire_d;
			end
			if (evt_take) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Register writes; each register keeps only its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q  <= '0;
			repeat_delay_q <= '0;
			accel_step_q   <= '0;
			min_delay_q    <= '0;
			up_default_q   <= 1'b0;
			up_policy_q    <= POL_DEFAULT;
			down_default_q <= 1'b0;
			down_policy_q  <= POL_DEFAULT;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_FIRST_DELAY:  first_delay_q  <= cfg.data[DELAY_BITS-1:0];
				REG_REPEAT_DELAY: repeat_delay_q <= cfg.data[DELAY_BITS-1:0];
				REG_ACCEL_STEP:   accel_step_q   <= cfg.data[DELAY_BITS-1:0];
				REG_MIN_DELAY:    min_delay_q    <= cfg.data[DELAY_BITS-1:0];
				REG_UP_DEFAULT:   up_default_q   <= cfg.data[0];
				REG_UP_POLICY:    up_policy_q    <= cfg.data[POLICY_BITS-1:0];
				REG_DOWN_DEFAULT: down_default_q <= cfg.data[0];
				REG_DOWN_POLICY:  down_policy_q  <= cfg.data[POLICY_BITS-1:0];
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	// An allowed release always fires
	a_release_fires: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_take && evt.key_up && policy_allows(up_policy_q, up_default_q))
		|=> (res.valid && res.fire))
		else $error("allowed release did not fire");

	// A denied press without release leaves the repeat state untouched
	a_denied_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_take && !evt.key_up && !policy_allows(down_policy_q, down_default_q))
		|=> ($stable(next_time_q) && $stable(cur_delay_q) && !res.fire))
		else $error("denied press changed state or fired");

	// After an allowed press the delay never sits below the floor
	a_delay_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_take && press) |=> (cur_delay_q >= $past(min_delay_q)))
		else $error("repeat delay below floor after press");

	// A release that fires leaves the key idle
	a_release_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_take && up_fire) |=> (next_time_q == '0 && cur_delay_q == '0))
		else $error("release did not clear repeat state");
`endif

endmodule
